// File: rtl/cmad_pkg.sv
// ----------------------------------------------------------------------------
// cmad_pkg
// Shared types, field widths and constants of the multichannel MAD meter.
// ----------------------------------------------------------------------------
package cmad_pkg;

    // Default sizes, handed down as top-level parameter defaults
    localparam int MAX_SAMPLES_DEF  = 256;
    localparam int MAX_CHANNELS_DEF = 8;

    // ADC sample width, fixed by the stream port
    localparam int SAMPLE_BITS = 12;

    // Fractional bits of the mean and deviation values
    localparam int Q_FRAC = 8;

    // Configuration register widths and reset values
    localparam int SPF_W       = 9;
    localparam int CHC_W       = 4;
    localparam int OFFSET_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [SPF_W-1:0]    SPF_RST    = 9'd256;
    localparam logic [CHC_W-1:0]    CHC_RST    = 4'd8;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'd399;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd22382;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPF    = 2'd0,
        REG_CHC    = 2'd1,
        REG_OFFSET = 2'd2,
        REG_GAIN   = 2'd3
    } cfg_reg_t;

    // Input item kind carried in s_tuser
    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_FRAME  = 1'b1
    } mode_t;

    // Result fields
    localparam int CH_FIELD_W  = 3;
    localparam int CNT_FIELD_W = 9;
    localparam int POWER_W     = 26;
    localparam int RESULT_W    = 2 * CH_FIELD_W + CNT_FIELD_W + POWER_W;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 48;

    // Power saturation: magnitude limits and the clipped codes
    localparam int POWER_MAG_POS = 33554431;
    localparam int POWER_MAG_NEG = 33554432;
    localparam logic [POWER_W-1:0] POWER_MAX = {1'b0, {(POWER_W-1){1'b1}}};
    localparam logic [POWER_W-1:0] POWER_MIN = {1'b1, {(POWER_W-1){1'b0}}};

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_DEV,
        ST_MAD_GO,
        ST_MAD_WAIT,
        ST_SIGN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_COMBINE,
        ST_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic store;        // write the sample tick into the frame store
        logic pass_clear;   // rewind the read pass, clear the accumulator
        logic rd_issue;     // read the next stored sample
        logic dev_pass;     // accumulate |sample - mean| instead of sample
        logic div_start;    // start the serial divider
        logic div_sel_mad;  // divider input: 1 = deviation sum, 0 = sample sum
        logic sign_load;    // form |mad - offset| and its sign
        logic mul_lo;       // low partial product with the gain
        logic mul_hi;       // high partial product with the gain
        logic combine;      // add partial products and drop gain fraction
        logic finish;       // load result, advance channel, reopen frame
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic rd_end;       // all held samples of the frame issued
        logic rd_pending;   // a read is still returning data
        logic div_busy;     // divider iterating
        logic out_free;     // result register can take a new result
    } status_t;

endpackage

// File: rtl/cmad_ram.sv
// ----------------------------------------------------------------------------
// cmad_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cmad_ram #(
    parameter int DATA_W = 12,
    parameter int DEPTH  = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/cmad_ctrl.sv
// ----------------------------------------------------------------------------
// cmad_ctrl
// Sequencer: takes stream items, runs the two store passes, both divisions,
// the gain multiply and the result hand-off for each frame tick.
// ----------------------------------------------------------------------------
module cmad_ctrl
    import cmad_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    s_tuser,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && (s_tuser == MODE_FRAME)) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (status.rd_end && !status.rd_pending) begin
                    state_next = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_DEV;
                end
            end
            ST_DEV: begin
                if (status.rd_end && !status.rd_pending) begin
                    state_next = ST_MAD_GO;
                end
            end
            ST_MAD_GO:   state_next = ST_MAD_WAIT;
            ST_MAD_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:    state_next = ST_MUL_LO;
            ST_MUL_LO:  state_next = ST_MUL_HI;
            ST_MUL_HI:  state_next = ST_COMBINE;
            ST_COMBINE: state_next = ST_FINISH;
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.store      = s_tvalid && (s_tuser == MODE_SAMPLE);
                cmd.pass_clear = s_tvalid && (s_tuser == MODE_FRAME);
            end
            ST_SUM: begin
                cmd.rd_issue = !status.rd_end;
            end
            ST_MEAN_GO: begin
                cmd.div_start = 1'b1;
            end
            ST_MEAN_WAIT: begin
                cmd.pass_clear = !status.div_busy;
            end
            ST_DEV: begin
                cmd.dev_pass = 1'b1;
                cmd.rd_issue = !status.rd_end;
            end
            ST_MAD_GO: begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_mad = 1'b1;
            end
            ST_MAD_WAIT: begin
                cmd.div_sel_mad = 1'b1;
            end
            ST_SIGN:    cmd.sign_load = 1'b1;
            ST_MUL_LO:  cmd.mul_lo    = 1'b1;
            ST_MUL_HI:  cmd.mul_hi    = 1'b1;
            ST_COMBINE: cmd.combine   = 1'b1;
            ST_FINISH:  cmd.finish    = status.out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/cmad_dp.sv
// ----------------------------------------------------------------------------
// cmad_dp
// Datapath: configuration registers, frame store, read-pass accumulator,
// bit-serial divider, split gain multiplier and the result register.
// ----------------------------------------------------------------------------
module cmad_dp
    import cmad_pkg::*;
#(
    parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [SAMPLE_BITS-1:0] sample_value,
    input  cmd_t                   cmd,
    output status_t                status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata
);

    localparam int IDX_W   = $clog2(MAX_SAMPLES + 1);
    localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DEPTH   = MAX_CHANNELS * MAX_SAMPLES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SUM_W   = SAMPLE_BITS + IDX_W;
    localparam int MEAN_W  = SUM_W + Q_FRAC;
    localparam int DEV_W   = MEAN_W + IDX_W;
    localparam int DCNT_W  = $clog2(DEV_W + 1);
    localparam int LO_W    = (DEV_W + 1) / 2;
    localparam int PRODP_W = LO_W + GAIN_W;
    localparam int PROD_W  = DEV_W + GAIN_W;
    localparam int SH_W    = PROD_W - GAIN_FRAC;
    localparam int SPC_W   = (IDX_W > SPF_W) ? IDX_W : SPF_W;
    localparam int CHL_W   = ((CH_W + 1) > CHC_W) ? (CH_W + 1) : CHC_W;
    localparam int CHX_W   = (CH_W > CH_FIELD_W) ? CH_W : CH_FIELD_W;
    localparam int CNX_W   = (IDX_W > CNT_FIELD_W) ? IDX_W : CNT_FIELD_W;
    localparam int PAD_W   = M_TDATA_W - RESULT_W;

    // Configuration registers
    logic [SPF_W-1:0]    spf_reg;
    logic [CHC_W-1:0]    chc_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [GAIN_W-1:0]   gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spf_reg    <= SPF_RST;
            chc_reg    <= CHC_RST;
            offset_reg <= OFFSET_RST;
            gain_reg   <= GAIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_SPF:    spf_reg    <= cfg_data[SPF_W-1:0];
                REG_CHC:    chc_reg    <= cfg_data[CHC_W-1:0];
                REG_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                REG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Frame limit, clamped to 1..MAX_SAMPLES
    logic [SPC_W-1:0] spf_x;
    logic [IDX_W-1:0] spf_eff;

    assign spf_x = SPC_W'(spf_reg);

    always_comb begin
        if (spf_x == '0) begin
            spf_eff = IDX_W'(1);
        end else if (spf_x > SPC_W'(MAX_SAMPLES)) begin
            spf_eff = IDX_W'(MAX_SAMPLES);
        end else begin
            spf_eff = spf_x[IDX_W-1:0];
        end
    end

    // Round-robin channel step, channel count clamped to 1..MAX_CHANNELS
    logic [CHL_W-1:0] chc_x;
    logic [CHL_W-1:0] ch_lim;
    logic [CHL_W-1:0] ch_inc;
    logic [CH_W-1:0]  ch_next;
    logic [CH_W-1:0]  cur_ch_reg;

    assign chc_x  = CHL_W'(chc_reg);
    assign ch_inc = CHL_W'(cur_ch_reg) + CHL_W'(1);

    always_comb begin
        if (chc_x == '0) begin
            ch_lim = CHL_W'(1);
        end else if (chc_x > CHL_W'(MAX_CHANNELS)) begin
            ch_lim = CHL_W'(MAX_CHANNELS);
        end else begin
            ch_lim = chc_x;
        end
    end

    assign ch_next = (ch_inc >= ch_lim) ? '0 : ch_inc[CH_W-1:0];

    // Frame store
    logic [IDX_W-1:0]       wr_idx_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   rd_vld_reg;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [ADDR_W-1:0]      frame_base;

    assign ram_we     = cmd.store && (wr_idx_reg < spf_eff);
    assign frame_base = ADDR_W'(cur_ch_reg) * ADDR_W'(MAX_SAMPLES);
    assign ram_waddr  = frame_base + ADDR_W'(wr_idx_reg);
    assign ram_raddr  = frame_base + ADDR_W'(rd_idx_reg);

    cmad_ram #(
        .DATA_W (SAMPLE_BITS),
        .DEPTH  (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read-pass accumulator: plain sum, or absolute deviation from the mean
    logic [DEV_W-1:0]  acc_reg;
    logic [DEV_W-1:0]  div_q_reg;
    logic [MEAN_W-1:0] mean;
    logic [MEAN_W-1:0] v8;
    logic [MEAN_W-1:0] absdev;
    logic [DEV_W-1:0]  acc_add;

    assign mean = div_q_reg[MEAN_W-1:0];
    assign v8   = MEAN_W'(ram_rdata) << Q_FRAC;

    always_comb begin
        absdev = (v8 >= mean) ? (v8 - mean) : (mean - v8);
        if (cmd.dev_pass) begin
            acc_add = DEV_W'(absdev);
        end else begin
            acc_add = DEV_W'(ram_rdata);
        end
    end

    // Serial divider by the frame limit, one quotient bit per cycle
    logic [IDX_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic              div_busy_reg;
    logic [DEV_W-1:0]  dividend;
    logic [IDX_W:0]    rem_sh;
    logic [IDX_W:0]    rem_sub;
    logic              q_bit;

    assign dividend = cmd.div_sel_mad ? acc_reg : (DEV_W'(acc_reg[SUM_W-1:0]) << Q_FRAC);
    assign rem_sh   = {rem_reg, div_q_reg[DEV_W-1]};
    assign rem_sub  = rem_sh - (IDX_W + 1)'(spf_eff);
    assign q_bit    = (rem_sh >= (IDX_W + 1)'(spf_eff));

    // Sign and magnitude of (mad - offset)
    logic [DEV_W:0]   diff;
    logic [DEV_W:0]   diff_neg;
    logic [DEV_W-1:0] mag_reg;
    logic             neg_reg;

    assign diff     = {1'b0, div_q_reg} - (DEV_W + 1)'(offset_reg);
    assign diff_neg = -diff;

    // Gain multiply in two partial products
    logic [LO_W-1:0]    mul_a;
    logic [PRODP_W-1:0] mul_p;
    logic [PRODP_W-1:0] plo_reg;
    logic [PRODP_W-1:0] phi_reg;
    logic [PROD_W-1:0]  prod_sum;
    logic [SH_W-1:0]    sh_reg;
    logic [SH_W-1:0]    sh_neg;
    logic [POWER_W-1:0] power;

    assign mul_a    = cmd.mul_hi ? LO_W'(mag_reg[DEV_W-1:LO_W]) : mag_reg[LO_W-1:0];
    assign mul_p    = PRODP_W'(mul_a) * PRODP_W'(gain_reg);
    assign prod_sum = (PROD_W'(phi_reg) << LO_W) + PROD_W'(plo_reg);
    assign sh_neg   = -sh_reg;

    // Saturate to the signed power range
    always_comb begin
        if (neg_reg) begin
            power = (sh_reg > SH_W'(POWER_MAG_NEG)) ? POWER_MIN : sh_neg[POWER_W-1:0];
        end else begin
            power = (sh_reg > SH_W'(POWER_MAG_POS)) ? POWER_MAX : sh_reg[POWER_W-1:0];
        end
    end

    // Result fields, widened then cut to the port widths
    logic [CHX_W-1:0] fin_x;
    logic [CHX_W-1:0] next_x;
    logic [CNX_W-1:0] cnt_x;

    assign fin_x  = CHX_W'(cur_ch_reg);
    assign next_x = CHX_W'(ch_next);
    assign cnt_x  = CNX_W'(wr_idx_reg);

    // Control registers
    logic out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg   <= '0;
            cur_ch_reg   <= '0;
            rd_idx_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_issue;
            if (ram_we) begin
                wr_idx_reg <= wr_idx_reg + IDX_W'(1);
            end
            if (cmd.pass_clear) begin
                rd_idx_reg <= '0;
            end else if (cmd.rd_issue) begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
            if (cmd.div_start) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= DCNT_W'(DEV_W);
            end else if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(1)) begin
                    div_busy_reg <= 1'b0;
                end
            end
            if (cmd.finish) begin
                cur_ch_reg  <= ch_next;
                wr_idx_reg  <= '0;
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    logic [M_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.pass_clear) begin
            acc_reg <= '0;
        end else if (rd_vld_reg) begin
            acc_reg <= acc_reg + acc_add;
        end
        if (cmd.div_start) begin
            rem_reg   <= '0;
            div_q_reg <= dividend;
        end else if (div_busy_reg) begin
            rem_reg   <= q_bit ? rem_sub[IDX_W-1:0] : rem_sh[IDX_W-1:0];
            div_q_reg <= {div_q_reg[DEV_W-2:0], q_bit};
        end
        if (cmd.sign_load) begin
            neg_reg <= diff[DEV_W];
            mag_reg <= diff[DEV_W] ? diff_neg[DEV_W-1:0] : diff[DEV_W-1:0];
        end
        if (cmd.mul_lo) begin
            plo_reg <= mul_p;
        end
        if (cmd.mul_hi) begin
            phi_reg <= mul_p;
        end
        if (cmd.combine) begin
            sh_reg <= prod_sum[PROD_W-1:GAIN_FRAC];
        end
        if (cmd.finish) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, power, cnt_x[CNT_FIELD_W-1:0],
                            next_x[CH_FIELD_W-1:0], fin_x[CH_FIELD_W-1:0]};
        end
    end

    assign status.rd_end     = (rd_idx_reg == wr_idx_reg);
    assign status.rd_pending = rd_vld_reg;
    assign status.div_busy   = div_busy_reg;
    assign status.out_free   = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/multichannel_current_mad_meter.sv
// Sample tick: written into the frame store as it is accepted; the next item is taken right after.
// Frame tick: a sum pass over the store, a bit-serial division for the mean, a deviation
// pass, a second bit-serial division for the MAD and the gain multiply, then m_tvalid;
// the divider is 38 bits wide at default sizes, and the store passes run at one read a cycle.
// The result waits in an output register; input stalls only while a frame tick runs.
// Reset (aresetn low, synchronous) sets channel 0, empty frame, register defaults.
// ----------------------------------------------------------------------------
// multichannel_current_mad_meter
// Per-channel sample frames, round-robin channels, scaled mean absolute
// deviation reported on each frame tick.
// ----------------------------------------------------------------------------
module multichannel_current_mad_meter
    import cmad_pkg::*;
#(
    parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [11:0] sample_value
    input  logic                   s_tuser,   // [0] mode
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // [2:0] finished_channel,
                                              // [5:3] next_channel,
                                              // [14:6] sample_count,
                                              // [40:15] power
);

    cmd_t    cmd;
    status_t status;

    cmad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    cmad_dp #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_value (s_tdata[SAMPLE_BITS-1:0]),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// File: tb/multichannel_current_mad_meter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_current_mad_meter_tb
// Self-checking bench for the MAD meter: drives sample and frame ticks
// with random idle cycles and back-pressure, and scores every power report
// against an in-bench predictor of the frame store, channel rotation and
// fixed-point deviation arithmetic.
// ----------------------------------------------------------------------------
module multichannel_current_mad_meter_tb;
    import cmad_pkg::*;

    localparam int MAX_SMP       = MAX_SAMPLES_DEF;
    localparam int MAX_CH        = MAX_CHANNELS_DEF;
    localparam int RANDOM_ITEMS  = 950;
    localparam int IDLE_PCT      = 18;
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_CYCLES   = 700;

    // One power report, packed in m_tdata order (top field first)
    typedef struct packed {
        logic [POWER_W-1:0]     power;
        logic [CNT_FIELD_W-1:0] count;
        logic [CH_FIELD_W-1:0]  next_ch;
        logic [CH_FIELD_W-1:0]  done_ch;
    } meter_report_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_SPF;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // [11:0] sample_value
    logic                   s_tuser   = MODE_SAMPLE;   // [0] mode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;  // [2:0] finished_channel, [5:3] next_channel,
                                      // [14:6] sample_count, [40:15] power

    // Predictor state
    logic [SAMPLE_BITS-1:0] frame_mem [0:MAX_CH-1][0:MAX_SMP-1];
    int                     fill_level;
    int                     active_ch;
    logic [SPF_W-1:0]       reg_spf;
    logic [CHC_W-1:0]       reg_chc;
    logic [OFFSET_W-1:0]    reg_offset;
    logic [GAIN_W-1:0]      reg_gain;
    meter_report_t          expected_reports [$];

    // Run bookkeeping
    bit no_idle = 1'b0;
    int err_count;
    int n_reports;
    int n_frames;
    int n_samples;
    int n_sent;
    int n_cfg_writes;

    multichannel_current_mad_meter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 125 MHz clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int eff_spf();
        if (reg_spf == 0) return 1;
        if (reg_spf > MAX_SMP) return MAX_SMP;
        return int'(reg_spf);
    endfunction

    function automatic int eff_chc();
        if (reg_chc == 0) return 1;
        if (reg_chc > MAX_CH) return MAX_CH;
        return int'(reg_chc);
    endfunction

    // Scaled mean absolute deviation of one closed frame
    function automatic logic [POWER_W-1:0] mad_power(int ch, int count, int divisor);
        longint unsigned sum;
        longint unsigned dev;
        longint unsigned mean;
        longint unsigned mad;
        longint unsigned mag;
        longint unsigned v;
        longint          diff;
        bit              neg;
        sum = 0;
        dev = 0;
        for (int i = 0; i < count; i++) sum += frame_mem[ch][i];
        mean = (sum << Q_FRAC) / longint'(divisor);
        for (int i = 0; i < count; i++) begin
            v = longint'(frame_mem[ch][i]) << Q_FRAC;
            dev += (v >= mean) ? (v - mean) : (mean - v);
        end
        mad  = dev / longint'(divisor);
        diff = longint'(mad) - longint'(reg_offset);
        neg  = diff < 0;
        mag  = neg ? longint'(-diff) : longint'(diff);
        mag  = (mag * longint'(reg_gain)) >> GAIN_FRAC;
        if (neg) begin
            return (mag > POWER_MAG_NEG) ? POWER_MIN : POWER_W'(-longint'(mag));
        end
        return (mag > POWER_MAG_POS) ? POWER_MAX : POWER_W'(mag);
    endfunction

    // Update the predictor for one accepted input transfer
    task automatic meter_accept(input mode_t mode, input logic [SAMPLE_BITS-1:0] value);
        meter_report_t rpt;
        int            nxt;
        if (mode == MODE_SAMPLE) begin
            // a full frame drops further samples
            if (fill_level < eff_spf()) begin
                frame_mem[active_ch][fill_level] = value;
                fill_level++;
                n_samples++;
            end
        end else begin
            nxt = active_ch + 1;
            if (nxt >= eff_chc()) nxt = 0;
            rpt.done_ch = active_ch[CH_FIELD_W-1:0];
            rpt.next_ch = nxt[CH_FIELD_W-1:0];
            rpt.count   = fill_level[CNT_FIELD_W-1:0];
            rpt.power   = mad_power(active_ch, fill_level, eff_spf());
            expected_reports.push_back(rpt);
            active_ch  = nxt;
            fill_level = 0;
            n_frames++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and scoring
    // ------------------------------------------------------------------
    task automatic check_report(input logic [M_TDATA_W-1:0] data);
        meter_report_t got;
        meter_report_t want;
        got = data[RESULT_W-1:0];
        if (expected_reports.size() == 0) begin
            $error("result transfer with no frame tick pending: %h", data);
            err_count++;
            return;
        end
        want = expected_reports.pop_front();
        if (got.done_ch !== want.done_ch) begin
            $error("finished_channel: expected %0d, got %0d", want.done_ch, got.done_ch);
            err_count++;
        end
        if (got.next_ch !== want.next_ch) begin
            $error("next_channel: expected %0d, got %0d", want.next_ch, got.next_ch);
            err_count++;
        end
        if (got.count !== want.count) begin
            $error("sample_count: expected %0d, got %0d", want.count, got.count);
            err_count++;
        end
        if (got.power !== want.power) begin
            $error("power: expected %0d, got %0d", $signed(want.power), $signed(got.power));
            err_count++;
        end
        n_reports++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_report(m_tdata);
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (each one returns right after a rising edge)
    // ------------------------------------------------------------------
    task automatic send_item(input mode_t mode, input logic [SAMPLE_BITS-1:0] value);
        while (!no_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_W-SAMPLE_BITS){1'b0}}, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
        meter_accept(mode, value);
    endtask

    // Stop sending until every pending report has come out
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_reports.size() != 0);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SPF:    reg_spf    = data[SPF_W-1:0];
            REG_CHC:    reg_chc    = data[CHC_W-1:0];
            REG_OFFSET: reg_offset = data[OFFSET_W-1:0];
            REG_GAIN:   reg_gain   = data[GAIN_W-1:0];
            default: begin
            end
        endcase
        n_cfg_writes++;
        @(posedge aclk);
    endtask

    // Registers change only with the block idle
    task automatic set_config(input int spf, input int chc, input int offset, input int gain);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_write(REG_SPF, CFG_DATA_W'(spf));
        cfg_write(REG_CHC, CFG_DATA_W'(chc));
        cfg_write(REG_OFFSET, CFG_DATA_W'(offset));
        cfg_write(REG_GAIN, CFG_DATA_W'(gain));
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int base, input int spread);
        int x;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4, 5: begin
                x = base + int'($urandom_range(0, 2 * spread)) - spread;
                if (x < 0) x = 0;
                if (x > 4095) x = 4095;
                return x[SAMPLE_BITS-1:0];
            end
            default: return SAMPLE_BITS'($urandom_range(0, 4095));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // empty frame, then extreme samples under the reset settings
        send_item(MODE_FRAME, SAMPLE_BITS'($urandom_range(0, 4095)));
        send_item(MODE_SAMPLE, 12'd0);
        send_item(MODE_SAMPLE, 12'd4095);
        send_item(MODE_SAMPLE, 12'd4095);
        send_item(MODE_SAMPLE, 12'd0);
        send_item(MODE_SAMPLE, 12'd2048);
        send_item(MODE_FRAME, 12'd0);
    endtask

    task automatic test_register_extremes();
        // one-sample frame: second sample dropped, max gain
        set_config(1, 1, 0, 65535);
        send_item(MODE_SAMPLE, 12'd4095);
        send_item(MODE_SAMPLE, 12'd0);
        send_item(MODE_FRAME, 12'd0);
        // zero limit and zero channel count read as one; max offset
        set_config(0, 0, 65535, 65535);
        send_item(MODE_SAMPLE, 12'd123);
        send_item(MODE_FRAME, 12'd0);
        // oversize limit and count clip to the maxima
        set_config(511, 15, 0, 4096);
        send_item(MODE_SAMPLE, 12'd0);
        send_item(MODE_SAMPLE, 12'd4095);
        send_item(MODE_FRAME, 12'd0);
    endtask

    task automatic test_channel_shrink();
        // walk to a high channel, then drop the count below it
        set_config(4, 8, 399, 22382);
        while (active_ch < 5) send_item(MODE_FRAME, 12'd0);
        set_config(4, 2, 399, 22382);
        send_item(MODE_SAMPLE, 12'd1000);
        send_item(MODE_FRAME, 12'd0);
    endtask

    task automatic test_limit_lowered();
        // hold ten samples, then cut the limit to one: divisor shrinks, power clips
        set_config(16, 8, 0, 65535);
        for (int i = 0; i < 10; i++) send_item(MODE_SAMPLE, (i % 2) ? 12'd4095 : 12'd0);
        set_config(1, 8, 0, 65535);
        send_item(MODE_FRAME, 12'd0);
    endtask

    task automatic test_random_frames();
        int start_items;
        int frames;
        int spf;
        int k;
        int base;
        int spread;
        start_items = n_sent;
        while (n_sent - start_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       spf = MAX_SMP;
                1:       spf = $urandom_range(25, MAX_SMP - 1);
                2:       spf = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_SMP + 1, 511);
                default: spf = $urandom_range(1, 24);
            endcase
            set_config(spf,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(1, 8),
                       ($urandom_range(0, 5) == 0) ? 65535 * $urandom_range(0, 1)
                                                    : $urandom_range(0, 3000),
                       ($urandom_range(0, 5) == 0) ? 65535 * $urandom_range(0, 1)
                                                    : $urandom_range(0, 65535));
            frames = (eff_spf() > 32) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            for (int f = 0; f < frames && (n_sent - start_items < RANDOM_ITEMS); f++) begin
                // the middle third of the run has no random idle cycles and no back-pressure
                no_idle = (n_sent - start_items >= RANDOM_ITEMS / 3) &&
                          (n_sent - start_items < 2 * RANDOM_ITEMS / 3);
                base   = $urandom_range(0, 4095);
                spread = $urandom_range(0, 64);
                // stray frame ticks close empty frames
                if ($urandom_range(0, 11) == 0) begin
                    send_item(MODE_FRAME, SAMPLE_BITS'($urandom_range(0, 4095)));
                end
                case ($urandom_range(0, 4))
                    0:       k = $urandom_range(0, eff_spf());
                    1:       k = eff_spf() + $urandom_range(1, 3);
                    default: k = eff_spf();
                endcase
                for (int i = 0; i < k && (n_sent - start_items < RANDOM_ITEMS - 1); i++) begin
                    send_item(MODE_SAMPLE, pick_sample(base, spread));
                end
                send_item(MODE_FRAME, SAMPLE_BITS'($urandom_range(0, 4095)));
                if ($urandom_range(0, 5) == 0) hold_until_drained();
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        fill_level = 0;
        active_ch  = 0;
        reg_spf    = SPF_RST;
        reg_chc    = CHC_RST;
        reg_offset = OFFSET_RST;
        reg_gain   = GAIN_RST;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_register_extremes();
        test_channel_shrink();
        test_limit_lowered();
        test_random_frames();

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d frame ticks and %0d stored samples over %0d register writes;",
                 n_frames, n_samples, n_cfg_writes);
        $display("%0d power reports scored, %0d mismatches.", n_reports, err_count);
        if (err_count == 0 && expected_reports.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (expected_reports.size() != 0) begin
                $error("%0d power reports never arrived", expected_reports.size());
            end
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/cmad_pkg.sv
rtl/cmad_ram.sv
rtl/cmad_ctrl.sv
rtl/cmad_dp.sv
rtl/multichannel_current_mad_meter.sv
tb/multichannel_current_mad_meter_tb.sv
